>>> hw/rtl/riat_pkg.sv
// ----------------------------------------------------------------------------
// riat_pkg: shared definitions of the random interval attract timer
// Request codes, register indexes, generator constants and the pitch table.
// ----------------------------------------------------------------------------
package riat_pkg;

    localparam logic [31:0] RNG_FALLBACK = 32'h6d2b_79f5;
    localparam logic [31:0] SEED_MIX     = 32'h4b49_4f53;

    localparam int RNG_SHL_A = 13;
    localparam int RNG_SHR_B = 17;
    localparam int RNG_SHL_C = 5;

    localparam logic [15:0] PITCH_COUNT = 16'd5;

    localparam logic [14:0] MIN_INTERVAL_RESET = 15'd600;
    localparam logic [14:0] MAX_INTERVAL_RESET = 15'd3600;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_INPUT  = 3'd1,
        REQ_SAMPLE = 3'd2,
        REQ_PITCH  = 3'd3,
        REQ_START  = 3'd4
    } t_req_type;

    typedef enum logic [1:0] {
        CFG_SEED    = 2'd0,
        CFG_MIN_INT = 2'd1,
        CFG_MAX_INT = 2'd2
    } t_cfg_index;

    // Pitch offset in semitones for a pick in [0, 5).
    function automatic logic signed [4:0] pitch_lookup(input logic [2:0] pick);
        logic signed [4:0] result;
        case (pick)
            3'd0:    result = -5'sd12;
            3'd1:    result = -5'sd7;
            3'd2:    result = 5'sd0;
            3'd3:    result = 5'sd7;
            3'd4:    result = 5'sd12;
            default: result = 5'sd0;
        endcase
        return result;
    endfunction

endpackage

>>> hw/rtl/riat_if.sv
// ----------------------------------------------------------------------------
// riat_if: channel interfaces of the random interval attract timer
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface riat_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] input_bits;
    logic [15:0] sample_total;
    logic [15:0] current_index;

    modport source (output valid, req_type, input_bits, sample_total, current_index,
                    input ready);
    modport sink   (input valid, req_type, input_bits, sample_total, current_index,
                    output ready);
endinterface

interface riat_rsp_if;
    logic              valid;
    logic              ready;
    logic              fired;
    logic              cancelled;
    logic              is_active;
    logic [15:0]       sample_index;
    logic signed [4:0] pitch_semitones;

    modport source (output valid, fired, cancelled, is_active, sample_index,
                    pitch_semitones, input ready);
    modport sink   (input valid, fired, cancelled, is_active, sample_index,
                    pitch_semitones, output ready);
endinterface

interface riat_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/riat_rng_pick.sv
// ----------------------------------------------------------------------------
// riat_rng_pick: one xorshift32 step and a multiply-high range pick
// Advances the word by (13, 17, 5), replaces zero, and scales it onto [0, n).
// ----------------------------------------------------------------------------
module riat_rng_pick
    import riat_pkg::*;
(
    input  logic [31:0] i_word,
    input  logic [15:0] i_range,
    output logic [31:0] o_word,
    output logic [15:0] o_pick
);

    logic [31:0] w_s1;
    logic [31:0] w_s2;
    logic [31:0] w_s3;
    logic [47:0] w_prod;

    always_comb begin
        w_s1   = i_word ^ (i_word << RNG_SHL_A);
        w_s2   = w_s1 ^ (w_s1 >> RNG_SHR_B);
        w_s3   = w_s2 ^ (w_s2 << RNG_SHL_C);
        o_word = (w_s3 == 32'd0) ? RNG_FALLBACK : w_s3;
        // High word of the 32x16 product is the pick in [0, n).
        w_prod = {16'd0, o_word} * {32'd0, i_range};
        o_pick = w_prod[47:32];
    end

endmodule

>>> hw/rtl/random_interval_attract_timer_unit.sv
// ----------------------------------------------------------------------------
// random_interval_attract_timer_unit: attract-mode timer with random intervals
// Frame-tick countdown, user cancel and random sample/pitch choices.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while the result channel takes
// its results, and returns exactly one result for each, through the request
// register and then the result register. The rate is set by the state update
// loop (generator word, active flag and countdown), which is one xorshift
// step, one 32x16 multiply-high and an add. The result register and the
// request register let a new request in while a finished result still
// waits on the result channel. Configuration writes are always ready and
// take effect on the next cycle; write them only while no request is in
// flight. Writes to indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module random_interval_attract_timer_unit
    import riat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    riat_req_if.sink    i_req,
    riat_rsp_if.source  o_rsp,
    riat_cfg_if.sink    i_cfg
);

    // Configuration registers.
    logic [31:0] r_seed;
    logic [14:0] r_min_int;
    logic [14:0] r_max_int;

    // Block state.
    logic [31:0] r_rng;
    logic        r_active;
    logic [15:0] r_frames;
    logic [31:0] n_rng;
    logic        n_active;
    logic [15:0] n_frames;

    // Request register.
    logic        r_req_valid;
    t_req_type   r_req_type;
    logic [15:0] r_input_bits;
    logic [15:0] r_sample_total;
    logic [15:0] r_current_index;

    // Result register.
    logic              r_rsp_valid;
    logic              r_fired;
    logic              r_cancelled;
    logic              r_is_active;
    logic [15:0]       r_sample_index;
    logic signed [4:0] r_pitch;
    logic              n_fired;
    logic              n_cancelled;
    logic [15:0]       n_sample_index;
    logic signed [4:0] n_pitch;

    logic w_advance;
    logic w_req_xfer;

    logic [31:0] w_seed_word;
    logic [31:0] w_src_word;
    logic [15:0] w_range;
    logic [31:0] w_next_word;
    logic [15:0] w_pick;
    logic [14:0] w_hi;
    logic [15:0] w_span;
    logic [15:0] w_interval;
    logic [15:0] w_cur;

    // The request stage moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign w_advance   = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready = !r_req_valid || w_advance;
    assign w_req_xfer  = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.fired           = r_fired;
    assign o_rsp.cancelled       = r_cancelled;
    assign o_rsp.is_active       = r_is_active;
    assign o_rsp.sample_index    = r_sample_index;
    assign o_rsp.pitch_semitones = r_pitch;

    // A start reseeds the generator before its interval draw.
    assign w_seed_word = ((r_seed ^ SEED_MIX) == 32'd0) ? RNG_FALLBACK : (r_seed ^ SEED_MIX);
    assign w_src_word  = (r_req_type == REQ_START) ? w_seed_word : r_rng;

    // Interval span: a maximum below the minimum counts as the minimum.
    assign w_hi   = (r_max_int < r_min_int) ? r_min_int : r_max_int;
    assign w_span = {1'b0, w_hi} - {1'b0, r_min_int} + 16'd1;

    // The shared multiplier scales onto the range that this request needs.
    always_comb begin
        case (r_req_type)
            REQ_SAMPLE: w_range = r_sample_total - 16'd1;
            REQ_PITCH:  w_range = PITCH_COUNT;
            default:    w_range = w_span;
        endcase
    end

    riat_rng_pick u_rng_pick (
        .i_word  (w_src_word),
        .i_range (w_range),
        .o_word  (w_next_word),
        .o_pick  (w_pick)
    );

    assign w_interval = {1'b0, r_min_int} + w_pick;
    assign w_cur      = (r_current_index >= r_sample_total) ? 16'd0 : r_current_index;

    // Single-pass request evaluation.
    always_comb begin
        n_rng          = r_rng;
        n_active       = r_active;
        n_frames       = r_frames;
        n_fired        = 1'b0;
        n_cancelled    = 1'b0;
        n_sample_index = 16'd0;
        n_pitch        = 5'sd0;
        case (r_req_type)
            REQ_TICK: begin
                if (r_active) begin
                    if (r_frames > 16'd1) begin
                        n_frames = r_frames - 16'd1;
                    end else begin
                        n_rng    = w_next_word;
                        n_frames = w_interval;
                        n_fired  = 1'b1;
                    end
                end
            end
            REQ_INPUT: begin
                if (r_active && (r_input_bits != 16'd0)) begin
                    n_active    = 1'b0;
                    n_frames    = 16'd0;
                    n_cancelled = 1'b1;
                end
            end
            REQ_SAMPLE: begin
                // With at most one sample the generator stays put.
                if (r_sample_total > 16'd1) begin
                    n_rng          = w_next_word;
                    n_sample_index = (w_pick >= w_cur) ? (w_pick + 16'd1) : w_pick;
                end
            end
            REQ_PITCH: begin
                n_rng   = w_next_word;
                n_pitch = pitch_lookup(w_pick[2:0]);
            end
            REQ_START: begin
                n_rng    = w_next_word;
                n_active = 1'b1;
                n_frames = w_interval;
            end
            default: begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= 32'd0;
            r_min_int <= MIN_INTERVAL_RESET;
            r_max_int <= MAX_INTERVAL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SEED:    r_seed    <= i_cfg.data;
                CFG_MIN_INT: r_min_int <= i_cfg.data[14:0];
                CFG_MAX_INT: r_max_int <= i_cfg.data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_req_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_xfer) begin
            r_req_type      <= t_req_type'(i_req.req_type);
            r_input_bits    <= i_req.input_bits;
            r_sample_total  <= i_req.sample_total;
            r_current_index <= i_req.current_index;
        end
    end

    // State and result register: both update when a request leaves the
    // request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng       <= RNG_FALLBACK;
            r_active    <= 1'b0;
            r_frames    <= 16'd0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_rsp_valid <= r_req_valid;
            end
            if (w_advance && r_req_valid) begin
                r_rng    <= n_rng;
                r_active <= n_active;
                r_frames <= n_frames;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_req_valid) begin
            r_fired        <= n_fired;
            r_cancelled    <= n_cancelled;
            r_is_active    <= n_active;
            r_sample_index <= n_sample_index;
            r_pitch        <= n_pitch;
        end
    end

endmodule
